@@ rtl/frame_deframer_xor_check_macros.svh @@
// Assertion helpers for the frame deframer.
`ifndef FRAME_DEFRAMER_XOR_CHECK_MACROS_SVH
`define FRAME_DEFRAMER_XOR_CHECK_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FDX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FDX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fdx_pkg.sv @@
package fdx_pkg;

  localparam int MaxPayloadDef = 32;
  localparam int ByteW         = 8;
  localparam int LenW          = 6;
  localparam int IdxW          = 5;
  localparam int HeldLenW      = 16;

  localparam logic [ByteW-1:0] StartByteRst = 8'hA5;

  typedef enum logic [2:0] {
    PhHunt,
    PhCmd,
    PhLenLo,
    PhLenHi,
    PhData,
    PhCheck,
    PhDrain
  } phase_e;

  // One result request from the parser to the output stage.
  typedef struct packed {
    logic             valid;
    logic             empty;
    logic             last;
    logic [IdxW-1:0]  idx;
    logic [ByteW-1:0] command;
    logic [LenW-1:0]  length;
  } fdx_issue_t;

endpackage

@@ rtl/fdx_rx_if.sv @@
interface fdx_rx_if import fdx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/fdx_frame_if.sv @@
interface fdx_frame_if import fdx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_command;
  logic [LenW-1:0]  frame_length;
  logic             has_data;
  logic [ByteW-1:0] data_byte;
  logic [IdxW-1:0]  byte_index;
  logic             last;

  modport source (output valid, output frame_command, output frame_length,
                  output has_data, output data_byte, output byte_index,
                  output last, input ready);
  modport sink (input valid, input frame_command, input frame_length,
                input has_data, input data_byte, input byte_index,
                input last, output ready);
endinterface

@@ rtl/fdx_payload_mem.sv @@
module fdx_payload_mem import fdx_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef,
  parameter int AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [ByteW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem [MaxPayload];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fdx_parser.sv @@
module fdx_parser import fdx_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef,
  parameter int AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             rx_valid_i,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             rx_ready_o,
  input  logic             slot_free_i,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [ByteW-1:0] mem_wdata_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  output fdx_issue_t       issue_o
);

  localparam logic [HeldLenW-1:0] MaxLen = HeldLenW'(MaxPayload);

  phase_e                phase_q, phase_d;
  logic [ByteW-1:0]      start_q;
  logic [ByteW-1:0]      cmd_q, cmd_d;
  logic [HeldLenW-1:0]   len_q, len_d;
  logic [LenW-1:0]       cnt_q, cnt_d;
  logic [ByteW-1:0]      xor_q, xor_d;

  logic                  accept;
  logic [HeldLenW-1:0]   len_full;
  logic [LenW-1:0]       cnt_inc;
  logic                  cnt_at_end;
  logic                  sum_ok;

  assign accept     = rx_valid_i && rx_ready_o;
  assign len_full   = {rx_byte_i, len_q[ByteW-1:0]};
  assign cnt_inc    = cnt_q + LenW'(1);
  assign cnt_at_end = HeldLenW'(cnt_inc) >= len_q;
  assign sum_ok     = rx_byte_i == xor_q;

  always_comb begin
    rx_ready_o = 1'b1;
    if (phase_q == PhDrain) begin
      rx_ready_o = 1'b0;
    end else if (phase_q == PhCheck) begin
      rx_ready_o = slot_free_i;
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    unique case (phase_q)
      PhHunt: begin
        if (accept && rx_byte_i == start_q) begin
          phase_d = PhCmd;
          xor_d   = '0;
        end
      end
      PhCmd: begin
        if (accept) begin
          cmd_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PhLenLo;
        end
      end
      PhLenLo: begin
        if (accept) begin
          len_d   = HeldLenW'(rx_byte_i);
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PhLenHi;
        end
      end
      PhLenHi: begin
        if (accept) begin
          cnt_d = '0;
          if (len_full > MaxLen) begin
            phase_d = PhHunt;
            cmd_d   = '0;
            len_d   = '0;
            xor_d   = '0;
          end else begin
            len_d   = len_full;
            xor_d   = xor_q ^ rx_byte_i;
            phase_d = (len_full == '0) ? PhCheck : PhData;
          end
        end
      end
      PhData: begin
        if (accept) begin
          cnt_d = cnt_inc;
          xor_d = xor_q ^ rx_byte_i;
          if (cnt_at_end) begin
            phase_d = PhCheck;
          end
        end
      end
      PhCheck: begin
        if (accept) begin
          if (sum_ok && len_q != '0) begin
            phase_d = PhDrain;
            cnt_d   = '0;
          end else begin
            phase_d = PhHunt;
            cmd_d   = '0;
            len_d   = '0;
            cnt_d   = '0;
            xor_d   = '0;
          end
        end
      end
      PhDrain: begin
        if (slot_free_i) begin
          cnt_d = cnt_inc;
          if (cnt_at_end) begin
            phase_d = PhHunt;
            cmd_d   = '0;
            len_d   = '0;
            cnt_d   = '0;
            xor_d   = '0;
          end
        end
      end
      default: begin
        phase_d = PhHunt;
        cmd_d   = '0;
        len_d   = '0;
        cnt_d   = '0;
        xor_d   = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    mem_we_o        = (phase_q == PhData) && accept;
    mem_waddr_o     = cnt_q[AddrW-1:0];
    mem_wdata_o     = rx_byte_i;
    mem_re_o        = (phase_q == PhDrain) && slot_free_i;
    mem_raddr_o     = cnt_q[AddrW-1:0];
    issue_o.valid   = mem_re_o ||
                      ((phase_q == PhCheck) && accept && sum_ok && len_q == '0);
    issue_o.empty   = phase_q == PhCheck;
    issue_o.last    = (phase_q == PhCheck) || cnt_at_end;
    issue_o.idx     = (phase_q == PhCheck) ? '0 : cnt_q[IdxW-1:0];
    issue_o.command = cmd_q;
    issue_o.length  = len_q[LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      start_q <= StartByteRst;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ rtl/fdx_out_stage.sv @@
module fdx_out_stage import fdx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fdx_issue_t       issue_i,
  input  logic [ByteW-1:0] rdata_i,
  output logic             slot_free_o,
  fdx_frame_if.source      frame_o
);

  fdx_issue_t       pend_q;
  logic             out_valid_q;
  logic [ByteW-1:0] cmd_q;
  logic [LenW-1:0]  len_q;
  logic             has_q;
  logic [ByteW-1:0] data_q;
  logic [IdxW-1:0]  idx_q;
  logic             last_q;

  // A request issued now is held in pend_q next cycle, when the output register is free.
  assign slot_free_o = !pend_q.valid && (!out_valid_q || frame_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= issue_i;
      if (pend_q.valid) begin
        out_valid_q <= 1'b1;
      end else if (frame_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q.valid) begin
      cmd_q  <= pend_q.command;
      len_q  <= pend_q.length;
      has_q  <= !pend_q.empty;
      data_q <= pend_q.empty ? '0 : rdata_i;
      idx_q  <= pend_q.idx;
      last_q <= pend_q.last;
    end
  end

  assign frame_o.valid         = out_valid_q;
  assign frame_o.frame_command = cmd_q;
  assign frame_o.frame_length  = len_q;
  assign frame_o.has_data      = has_q;
  assign frame_o.data_byte     = data_q;
  assign frame_o.byte_index    = idx_q;
  assign frame_o.last          = last_q;

endmodule

@@ rtl/frame_deframer_xor_check.sv @@
// Byte-serial frame deframer with XOR checksum.
// rx_i takes one received byte per request (valid/ready). The parser hunts
// for the start byte, then reads command, 16-bit little-endian length,
// payload and checksum; payload bytes go into the payload RAM.
// cfg_we_i/cfg_wdata_i load the start byte (0xA5 after reset); write only
// while no frame is in flight.
// While parsing, one byte is taken per cycle. On a matching checksum the
// frame is emitted on frame_o, one request per payload byte (or one empty
// request for a zero-length frame). Each result needs a registered RAM read;
// no read starts until the last result has left the pending register.
// After its checksum byte a non-empty frame enters the drain state; each
// result passes the pending and output registers. rx_i is held off while
// the RAM is being drained. Mismatched or oversize frames are dropped.
// When frame_o stalls, the finished result waits in the output register and
// draining pauses; the checksum byte is taken only when the output stage
// has room. Reset clears the parser and output valid at once; the RAM holds
// no reset state and needs no clearing pass.
module frame_deframer_xor_check import fdx_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  fdx_rx_if.sink           rx_i,
  fdx_frame_if.source      frame_o
);

`include "frame_deframer_xor_check_macros.svh"

  localparam int AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  fdx_issue_t       issue;
  logic             slot_free;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [ByteW-1:0] mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [ByteW-1:0] mem_rdata;

  fdx_parser #(
    .MaxPayload (MaxPayload),
    .AddrW      (AddrW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_valid_i  (rx_i.valid),
    .rx_byte_i   (rx_i.rx_byte),
    .rx_ready_o  (rx_i.ready),
    .slot_free_i (slot_free),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .issue_o     (issue)
  );

  fdx_payload_mem #(
    .MaxPayload (MaxPayload),
    .AddrW      (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fdx_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .rdata_i     (mem_rdata),
    .slot_free_o (slot_free),
    .frame_o     (frame_o)
  );

  `FDX_ASSERT_NOW(a_issue_room, issue.valid, slot_free, "result issued without room")
  `FDX_ASSERT_NEXT(a_issue_spacing, issue.valid, !issue.valid, "back-to-back issue")
  `FDX_ASSERT_NOW(a_empty_last, issue.valid && issue.empty, issue.last, "empty not last")
  `FDX_ASSERT_NOW(a_no_rx_on_read, mem_re, !(rx_i.valid && rx_i.ready), "rx during drain")

endmodule

@@ tb/tb_frame_deframer_xor_check.sv @@
`timescale 1ns / 100ps

module tb_frame_deframer_xor_check import fdx_pkg::*; ();

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 10;

  typedef struct packed {
    logic [ByteW-1:0] command;
    logic [LenW-1:0]  length;
    logic             has_data;
    logic [ByteW-1:0] data;
    logic [IdxW-1:0]  idx;
    logic             last;
  } frame_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [ByteW-1:0] cfg_wdata;

  fdx_rx_if    rx_bus ();
  fdx_frame_if frame_bus ();

  frame_deframer_xor_check i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .rx_i        (rx_bus),
    .frame_o     (frame_bus)
  );

  // Parser shadow state
  phase_e              parse_phase;
  logic [ByteW-1:0]    start_byte_q;
  logic [ByteW-1:0]    held_command;
  logic [HeldLenW-1:0] held_length;
  logic [LenW-1:0]     payload_count;
  logic [ByteW-1:0]    running_xor;
  logic [ByteW-1:0]    payload_shadow [MaxPayloadDef];

  frame_result_t pending_results [$];

  bit idle_on;
  int mismatches = 0;
  int results_checked = 0;
  int bytes_sent;
  int frames_passed;
  int frames_dropped;
  int stall_left = 0;
  int quiet_cycles = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void clear_parser();
    parse_phase   = PhHunt;
    held_command  = '0;
    held_length   = '0;
    payload_count = '0;
    running_xor   = '0;
  endfunction

  // Advance the shadow parser by one received byte and queue any frame output.
  function automatic void parse_rx_byte(input logic [ByteW-1:0] b);
    frame_result_t r;
    case (parse_phase)
      PhHunt: begin
        if (b == start_byte_q) begin
          parse_phase = PhCmd;
          running_xor = '0;
        end
      end
      PhCmd: begin
        held_command = b;
        running_xor ^= b;
        parse_phase = PhLenLo;
      end
      PhLenLo: begin
        held_length = {8'h00, b};
        running_xor ^= b;
        parse_phase = PhLenHi;
      end
      PhLenHi: begin
        held_length[15:8] = b;
        running_xor ^= b;
        payload_count = '0;
        if (held_length > MaxPayloadDef) begin
          frames_dropped++;
          clear_parser();
        end else if (held_length == 0) begin
          parse_phase = PhCheck;
        end else begin
          parse_phase = PhData;
        end
      end
      PhData: begin
        payload_shadow[payload_count] = b;
        payload_count = payload_count + 1'b1;
        running_xor ^= b;
        if (payload_count >= held_length) parse_phase = PhCheck;
      end
      PhCheck: begin
        if (b == running_xor) begin
          frames_passed++;
          r.command = held_command;
          r.length  = held_length[LenW-1:0];
          if (held_length == 0) begin
            r.has_data = 1'b0;
            r.data     = '0;
            r.idx      = '0;
            r.last     = 1'b1;
            pending_results.push_back(r);
          end else begin
            for (int k = 0; k < held_length; k++) begin
              r.has_data = 1'b1;
              r.data     = payload_shadow[k];
              r.idx      = k[IdxW-1:0];
              r.last     = (k + 1 == held_length);
              pending_results.push_back(r);
            end
          end
        end else begin
          frames_dropped++;
        end
        clear_parser();
      end
      default: clear_parser();
    endcase
  endfunction

  // Drive one byte at the falling edge and hold it until the request is taken.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      rx_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_bus.valid   = 1'b1;
    rx_bus.rx_byte = b;
    do @(posedge clk_i); while (!rx_bus.ready);
    bytes_sent++;
    parse_rx_byte(b);
  endtask

  task automatic release_rx();
    @(negedge clk_i);
    rx_bus.valid = 1'b0;
  endtask

  task automatic send_frame(input logic [ByteW-1:0] cmd, input logic [HeldLenW-1:0] len,
                            input bit corrupt);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] d;
    send_byte(start_byte_q);
    send_byte(cmd);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    sum = cmd ^ len[7:0] ^ len[15:8];
    if (len <= MaxPayloadDef) begin
      for (int i = 0; i < len; i++) begin
        d = 8'($urandom);
        sum ^= d;
        send_byte(d);
      end
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      send_byte(sum);
    end
  endtask

  // Finish any open frame, wait for output to drain, then load the start byte.
  task automatic load_start_byte(input logic [ByteW-1:0] value);
    while (parse_phase != PhHunt) send_byte(start_byte_q ^ 8'h01);
    release_rx();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    start_byte_q = value;
  endtask

  task automatic test_directed();
    logic [ByteW-1:0] seq [$];
    seq = '{8'h00, 8'hFF,
            // empty frame whose checksum equals the start byte
            8'hA5, 8'hA5, 8'h00, 8'h00, 8'hA5,
            // one payload byte of all ones
            8'hA5, 8'h00, 8'h01, 8'h00, 8'hFF, 8'hFE,
            // length one past the store
            8'hA5, 8'h11, 8'h21, 8'h00,
            // oversize with high length byte equal to the start byte
            8'hA5, 8'h22, 8'h00, 8'hA5,
            // bad checksum that looks like a start byte
            8'hA5, 8'h5A, 8'h00, 8'h00, 8'hA5};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_random_frames(input int budget);
    int base;
    int pick;
    int len_pick;
    logic [HeldLenW-1:0] len;
    base = bytes_sent;
    while (bytes_sent - base < budget) begin
      pick     = $urandom_range(0, 99);
      len_pick = $urandom_range(0, 99);
      if (len_pick < 6) len = HeldLenW'(MaxPayloadDef);
      else if (len_pick < 16) len = '0;
      else if (len_pick < 26) len = HeldLenW'($urandom_range(9, MaxPayloadDef - 1));
      else len = HeldLenW'($urandom_range(1, 8));
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else if (pick < 16) begin
        if ($urandom_range(0, 1)) len = HeldLenW'($urandom_range(MaxPayloadDef + 1, 255));
        else len = {8'($urandom_range(1, 255)), 8'($urandom)};
        send_frame(8'($urandom), len, 1'b0);
      end else if (pick < 28) begin
        send_frame(8'($urandom), len, 1'b1);
      end else begin
        send_frame(8'($urandom), len, 1'b0);
      end
    end
  endtask

  task automatic test_start_byte_extremes();
    load_start_byte(8'h00);
    test_random_frames(55);
    load_start_byte(8'hFF);
    test_random_frames(55);
  endtask

  task automatic test_random_start_byte();
    load_start_byte(8'($urandom));
    test_random_frames(55);
  endtask

  task automatic test_full_rate();
    load_start_byte(StartByteRst);
    idle_on = 1'b0;
    test_random_frames(50);
  endtask

  // Sink side: random stall bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      frame_bus.ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      frame_bus.ready = 1'b0;
    end else begin
      frame_bus.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_ni && frame_bus.valid && frame_bus.ready) begin
      got.command  = frame_bus.frame_command;
      got.length   = frame_bus.frame_length;
      got.has_data = frame_bus.has_data;
      got.data     = frame_bus.data_byte;
      got.idx      = frame_bus.byte_index;
      got.last     = frame_bus.last;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result %p", $time, got);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.command !== want.command || got.length !== want.length ||
            got.has_data !== want.has_data || got.data !== want.data ||
            got.idx !== want.idx || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: expected %p got %p", $time, want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_bus.valid && rx_bus.ready) || (frame_bus.valid && frame_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rx_bus.valid    = 1'b0;
    rx_bus.rx_byte  = '0;
    idle_on         = 1'b1;
    bytes_sent      = 0;
    frames_passed   = 0;
    frames_dropped  = 0;
    start_byte_q    = StartByteRst;
    clear_parser();
    foreach (payload_shadow[i]) payload_shadow[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_start_byte_extremes();
    test_random_start_byte();
    test_full_rate();

    release_rx();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d bytes with the reset, zero, all-ones and a random start byte.",
             bytes_sent);
    $display("%0d frames passed the checksum, %0d dropped; %0d results checked.",
             frames_passed, frames_dropped, results_checked);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
